[hw/rtl/permutation_move_engine_assert.svh]
// assertion macros for the permutation move engine
`ifndef PERMUTATION_MOVE_ENGINE_ASSERT_SVH
`define PERMUTATION_MOVE_ENGINE_ASSERT_SVH

// same-cycle implication
`define PMV_ASSERT_SAME(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("pmv same-cycle check failed");

// next-cycle implication
`define PMV_ASSERT_NEXT(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("pmv next-cycle check failed");

`endif

[hw/rtl/pmv_pkg.sv]
// shared types and constants for the permutation move engine
package pmv_pkg;

    localparam int MAX_ELEMENTS = 32;
    localparam int IDX_W        = 5;
    localparam int LEN_W        = 6;

    typedef enum logic [2:0] {
        OP_EXCHANGE   = 3'd0,
        OP_ROTATE     = 3'd1,
        OP_GROW       = 3'd2,
        OP_SHRINK     = 3'd3,
        OP_COMMIT     = 3'd4,
        OP_REVERT     = 3'd5,
        OP_READ       = 3'd6,
        OP_INITIALIZE = 3'd7
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_RANGE  = 2'd1,
        ST_AT_MAX = 2'd2,
        ST_AT_MIN = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        KIND_NONE   = 2'd0,
        KIND_CHANGE = 2'd1,
        KIND_PLACE  = 2'd2,
        KIND_REMOVE = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        REG_VALUE_COUNT  = 2'd0,
        REG_MIN_LENGTH   = 2'd1,
        REG_MAX_LENGTH   = 2'd2,
        REG_START_LENGTH = 2'd3
    } reg_index_t;

    typedef struct packed {
        logic [LEN_W-1:0] value_count;
        logic [LEN_W-1:0] min_length;
        logic [LEN_W-1:0] max_length;
        logic [LEN_W-1:0] start_length;
    } cfg_t;

    typedef struct packed {
        logic             fail;
        status_t          code;
        logic [LEN_W-1:0] count;
    } check_t;

    typedef struct packed {
        logic             clear;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        logic [IDX_W-1:0] wr_data;
        logic [IDX_W-1:0] rd_addr;
    } store_req_t;

endpackage

[hw/rtl/pmv_store.sv]
// element memory with per-entry valid bits; an unwritten entry reads as its own index
module pmv_store (
    input  logic                    clk,
    input  logic                    rst_n,
    input  pmv_pkg::store_req_t     req,
    output logic [pmv_pkg::IDX_W-1:0] rd_data
);

    logic [pmv_pkg::IDX_W-1:0]        mem [pmv_pkg::MAX_ELEMENTS];
    logic [pmv_pkg::MAX_ELEMENTS-1:0] valid_reg;
    logic [pmv_pkg::IDX_W-1:0]        mem_q_reg;
    logic [pmv_pkg::IDX_W-1:0]        addr_q_reg;
    logic                             valid_q_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        mem_q_reg  <= mem[req.rd_addr];
        addr_q_reg <= req.rd_addr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            valid_q_reg <= 1'b0;
        end
        else
        begin
            valid_q_reg <= valid_reg[req.rd_addr];
            if (req.clear)
            begin
                valid_reg <= '0;
            end
            else if (req.wr_en)
            begin
                valid_reg[req.wr_addr] <= 1'b1;
            end
        end
    end

    assign rd_data = valid_q_reg ? mem_q_reg : addr_q_reg;

endmodule

[hw/rtl/pmv_check.sv]
// range and length limit checks for one command
module pmv_check (
    input  pmv_pkg::opcode_t          op,
    input  logic [pmv_pkg::IDX_W-1:0] a,
    input  logic [pmv_pkg::IDX_W-1:0] b,
    input  logic [pmv_pkg::LEN_W-1:0] cur_len,
    input  pmv_pkg::cfg_t             cfg,
    output pmv_pkg::check_t           chk
);

    logic [pmv_pkg::LEN_W-1:0] n;
    logic [pmv_pkg::LEN_W-1:0] a_w;
    logic [pmv_pkg::LEN_W-1:0] b_w;
    logic                      pair_out;

    always_comb
    begin
        if (cfg.value_count == '0)
        begin
            n = pmv_pkg::LEN_W'(1);
        end
        else if (cfg.value_count > pmv_pkg::LEN_W'(pmv_pkg::MAX_ELEMENTS))
        begin
            n = pmv_pkg::LEN_W'(pmv_pkg::MAX_ELEMENTS);
        end
        else
        begin
            n = cfg.value_count;
        end
    end

    assign a_w      = {1'b0, a};
    assign b_w      = {1'b0, b};
    assign pair_out = (a_w >= n) || (b_w >= n);

    always_comb
    begin
        chk.count = n;
        chk.fail  = 1'b0;
        chk.code  = pmv_pkg::ST_OK;
        unique case (op)
            pmv_pkg::OP_EXCHANGE:
            begin
                if (pair_out)
                begin
                    chk.fail = 1'b1;
                    chk.code = pmv_pkg::ST_RANGE;
                end
            end
            pmv_pkg::OP_ROTATE:
            begin
                if (pair_out || (a_w >= cur_len) || (b_w >= cur_len))
                begin
                    chk.fail = 1'b1;
                    chk.code = pmv_pkg::ST_RANGE;
                end
            end
            pmv_pkg::OP_GROW:
            begin
                if ((cur_len >= cfg.max_length) || (cur_len >= n))
                begin
                    chk.fail = 1'b1;
                    chk.code = pmv_pkg::ST_AT_MAX;
                end
            end
            pmv_pkg::OP_SHRINK:
            begin
                if ((cur_len <= cfg.min_length) || (cur_len == '0))
                begin
                    chk.fail = 1'b1;
                    chk.code = pmv_pkg::ST_AT_MIN;
                end
            end
            pmv_pkg::OP_READ:
            begin
                if (a_w >= n)
                begin
                    chk.fail = 1'b1;
                    chk.code = pmv_pkg::ST_RANGE;
                end
            end
            pmv_pkg::OP_COMMIT, pmv_pkg::OP_REVERT, pmv_pkg::OP_INITIALIZE:
            begin
                chk.fail = 1'b0;
            end
        endcase
    end

endmodule

[hw/rtl/permutation_move_engine.sv]
// top level: command sequencer of the permutation move engine
// A command is taken when start is high and busy is low; busy then stays high at least until the
// cycle that carries the command's last result. Results come one per cycle on result_strobe,
// each for a single cycle, and the receiver cannot stall them; last marks the final one. Each of
// the two memories has one read and one write port, so the time from one accepted command to
// the next is set by the number of accesses: errors, initialize and the trivial cases end at
// decode, read, grow and shrink make one read, exchange reads both entries and writes them back,
// rotate reads and writes each position it passes, and commit and revert copy the whole store
// one entry a cycle between the two memories. Configuration writes go through cfg_write,
// cfg_index and cfg_data and should only be made while busy is low.
`include "permutation_move_engine_assert.svh"

module permutation_move_engine (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [2:0]                        opcode,
    input  logic [pmv_pkg::IDX_W-1:0]         first_index,
    input  logic [pmv_pkg::IDX_W-1:0]         second_index,
    output logic                              busy,
    input  logic                              cfg_write,
    input  logic [1:0]                        cfg_index,
    input  logic [pmv_pkg::LEN_W-1:0]         cfg_data,
    output logic                              result_strobe,
    output logic [1:0]                        status,
    output logic [1:0]                        kind,
    output logic [pmv_pkg::IDX_W-1:0]         position,
    output logic [pmv_pkg::IDX_W-1:0]         old_value,
    output logic [pmv_pkg::IDX_W-1:0]         new_value,
    output logic [pmv_pkg::LEN_W-1:0]         visible_length,
    output logic signed [pmv_pkg::LEN_W:0]    length_change,
    output logic                              last
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_EX_RB,
        S_EX_WA,
        S_EX_WB,
        S_RO_FIRST,
        S_RO_STEP,
        S_GR_EMIT,
        S_SH_EMIT,
        S_RD_EMIT,
        S_COPY
    } state_t;

    typedef struct packed {
        pmv_pkg::status_t          status;
        pmv_pkg::kind_t            kind;
        logic [pmv_pkg::IDX_W-1:0] position;
        logic [pmv_pkg::IDX_W-1:0] old_value;
        logic [pmv_pkg::IDX_W-1:0] new_value;
        logic                      last;
    } result_t;

    function automatic result_t make_result(
        input pmv_pkg::status_t          st,
        input pmv_pkg::kind_t            kd,
        input logic [pmv_pkg::IDX_W-1:0] pos,
        input logic [pmv_pkg::IDX_W-1:0] ov,
        input logic [pmv_pkg::IDX_W-1:0] nv,
        input logic                      lst
    );
        result_t r;
        r.status    = st;
        r.kind      = kd;
        r.position  = pos;
        r.old_value = ov;
        r.new_value = nv;
        r.last      = lst;
        return r;
    endfunction

    state_t                    state_reg, state_next;
    pmv_pkg::opcode_t          op_reg, op_next;
    logic [pmv_pkg::IDX_W-1:0] a_reg, a_next;
    logic [pmv_pkg::IDX_W-1:0] b_reg, b_next;
    logic [pmv_pkg::IDX_W-1:0] cnt_reg, cnt_next;
    logic [pmv_pkg::IDX_W-1:0] carry_reg, carry_next;
    logic [pmv_pkg::IDX_W-1:0] va_reg, va_next;
    logic [pmv_pkg::LEN_W-1:0] cur_len_reg, cur_len_next;
    logic [pmv_pkg::LEN_W-1:0] com_len_reg, com_len_next;
    pmv_pkg::cfg_t             cfg_reg, cfg_next;
    logic                      strobe_reg, strobe_next;
    result_t                   result_reg, result_next;

    pmv_pkg::store_req_t       elem_req, com_req;
    logic [pmv_pkg::IDX_W-1:0] elem_rd, com_rd;
    pmv_pkg::check_t           chk;

    logic                      a_vis, b_vis, rot_up;
    logic [pmv_pkg::LEN_W-1:0] cur_dec;
    logic [pmv_pkg::LEN_W-1:0] init_len;
    logic [pmv_pkg::IDX_W-1:0] step_next;
    logic [pmv_pkg::IDX_W-1:0] copy_data;
    logic [pmv_pkg::LEN_W:0]   len_diff;

    pmv_store u_elem (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (elem_req),
        .rd_data (elem_rd)
    );

    pmv_store u_committed (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (com_req),
        .rd_data (com_rd)
    );

    pmv_check u_check (
        .op      (op_reg),
        .a       (a_reg),
        .b       (b_reg),
        .cur_len (cur_len_reg),
        .cfg     (cfg_reg),
        .chk     (chk)
    );

    assign a_vis     = {1'b0, a_reg} < cur_len_reg;
    assign b_vis     = {1'b0, b_reg} < cur_len_reg;
    assign rot_up    = b_reg > a_reg;
    assign cur_dec   = cur_len_reg - pmv_pkg::LEN_W'(1);
    assign init_len  = (cfg_reg.start_length < chk.count) ? cfg_reg.start_length : chk.count;
    assign step_next = rot_up ? (cnt_reg + pmv_pkg::IDX_W'(1)) : (cnt_reg - pmv_pkg::IDX_W'(1));
    assign copy_data = (op_reg == pmv_pkg::OP_COMMIT) ? elem_rd : com_rd;

    // configuration writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (pmv_pkg::reg_index_t'(cfg_index))
                pmv_pkg::REG_VALUE_COUNT:  cfg_next.value_count  = cfg_data;
                pmv_pkg::REG_MIN_LENGTH:   cfg_next.min_length   = cfg_data;
                pmv_pkg::REG_MAX_LENGTH:   cfg_next.max_length   = cfg_data;
                pmv_pkg::REG_START_LENGTH: cfg_next.start_length = cfg_data;
            endcase
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        op_next      = op_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        cnt_next     = cnt_reg;
        carry_next   = carry_reg;
        va_next      = va_reg;
        cur_len_next = cur_len_reg;
        com_len_next = com_len_reg;
        strobe_next  = 1'b0;
        result_next  = result_reg;
        elem_req     = '0;
        com_req      = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next    = pmv_pkg::opcode_t'(opcode);
                    a_next     = first_index;
                    b_next     = second_index;
                    state_next = S_DECODE;
                end
            end

            S_DECODE:
            begin
                if (chk.fail)
                begin
                    strobe_next = 1'b1;
                    result_next = make_result(chk.code, pmv_pkg::KIND_NONE, '0, '0, '0, 1'b1);
                    state_next  = S_IDLE;
                end
                else
                begin
                    unique case (op_reg)
                        pmv_pkg::OP_EXCHANGE, pmv_pkg::OP_ROTATE:
                        begin
                            if (a_reg == b_reg)
                            begin
                                strobe_next = 1'b1;
                                result_next = make_result(pmv_pkg::ST_OK, pmv_pkg::KIND_NONE,
                                                          '0, '0, '0, 1'b1);
                                state_next  = S_IDLE;
                            end
                            else if (op_reg == pmv_pkg::OP_EXCHANGE)
                            begin
                                elem_req.rd_addr = a_reg;
                                state_next       = S_EX_RB;
                            end
                            else
                            begin
                                elem_req.rd_addr = b_reg;
                                state_next       = S_RO_FIRST;
                            end
                        end
                        pmv_pkg::OP_GROW:
                        begin
                            elem_req.rd_addr = cur_len_reg[pmv_pkg::IDX_W-1:0];
                            state_next       = S_GR_EMIT;
                        end
                        pmv_pkg::OP_SHRINK:
                        begin
                            elem_req.rd_addr = cur_dec[pmv_pkg::IDX_W-1:0];
                            cur_len_next     = cur_dec;
                            state_next       = S_SH_EMIT;
                        end
                        pmv_pkg::OP_COMMIT:
                        begin
                            elem_req.rd_addr = '0;
                            com_len_next     = cur_len_reg;
                            cnt_next         = '0;
                            state_next       = S_COPY;
                        end
                        pmv_pkg::OP_REVERT:
                        begin
                            com_req.rd_addr = '0;
                            cur_len_next    = com_len_reg;
                            cnt_next        = '0;
                            state_next      = S_COPY;
                        end
                        pmv_pkg::OP_READ:
                        begin
                            elem_req.rd_addr = a_reg;
                            state_next       = S_RD_EMIT;
                        end
                        pmv_pkg::OP_INITIALIZE:
                        begin
                            elem_req.clear = 1'b1;
                            com_req.clear  = 1'b1;
                            cur_len_next   = init_len;
                            com_len_next   = init_len;
                            strobe_next    = 1'b1;
                            result_next    = make_result(pmv_pkg::ST_OK, pmv_pkg::KIND_NONE,
                                                         '0, '0, '0, 1'b1);
                            state_next     = S_IDLE;
                        end
                    endcase
                end
            end

            S_EX_RB:
            begin
                elem_req.rd_addr = b_reg;
                va_next          = elem_rd;
                state_next       = S_EX_WA;
            end

            S_EX_WA:
            begin
                elem_req.wr_en   = 1'b1;
                elem_req.wr_addr = a_reg;
                elem_req.wr_data = elem_rd;
                carry_next       = elem_rd;
                if (a_vis)
                begin
                    strobe_next = 1'b1;
                    result_next = make_result(pmv_pkg::ST_OK, pmv_pkg::KIND_CHANGE,
                                              a_reg, va_reg, elem_rd, !b_vis);
                end
                state_next = S_EX_WB;
            end

            S_EX_WB:
            begin
                elem_req.wr_en   = 1'b1;
                elem_req.wr_addr = b_reg;
                elem_req.wr_data = va_reg;
                if (b_vis)
                begin
                    strobe_next = 1'b1;
                    result_next = make_result(pmv_pkg::ST_OK, pmv_pkg::KIND_CHANGE,
                                              b_reg, carry_reg, va_reg, 1'b1);
                end
                else if (!a_vis)
                begin
                    strobe_next = 1'b1;
                    result_next = make_result(pmv_pkg::ST_OK, pmv_pkg::KIND_NONE,
                                              '0, '0, '0, 1'b1);
                end
                state_next = S_IDLE;
            end

            S_RO_FIRST:
            begin
                carry_next       = elem_rd;
                elem_req.rd_addr = a_reg;
                cnt_next         = a_reg;
                state_next       = S_RO_STEP;
            end

            S_RO_STEP:
            begin
                // entry at cnt arrives now; it takes the carried value and becomes the carry
                elem_req.wr_en   = 1'b1;
                elem_req.wr_addr = cnt_reg;
                elem_req.wr_data = carry_reg;
                carry_next       = elem_rd;
                strobe_next      = 1'b1;
                result_next      = make_result(pmv_pkg::ST_OK, pmv_pkg::KIND_CHANGE,
                                               cnt_reg, elem_rd, carry_reg, cnt_reg == b_reg);
                if (cnt_reg == b_reg)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    elem_req.rd_addr = step_next;
                    cnt_next         = step_next;
                end
            end

            S_GR_EMIT:
            begin
                strobe_next  = 1'b1;
                result_next  = make_result(pmv_pkg::ST_OK, pmv_pkg::KIND_PLACE,
                                           cur_len_reg[pmv_pkg::IDX_W-1:0], '0, elem_rd, 1'b1);
                cur_len_next = cur_len_reg + pmv_pkg::LEN_W'(1);
                state_next   = S_IDLE;
            end

            S_SH_EMIT:
            begin
                strobe_next = 1'b1;
                result_next = make_result(pmv_pkg::ST_OK, pmv_pkg::KIND_REMOVE,
                                          cur_len_reg[pmv_pkg::IDX_W-1:0], elem_rd, '0, 1'b1);
                state_next  = S_IDLE;
            end

            S_RD_EMIT:
            begin
                strobe_next = 1'b1;
                result_next = make_result(pmv_pkg::ST_OK, pmv_pkg::KIND_NONE,
                                          a_reg, '0, elem_rd, 1'b1);
                state_next  = S_IDLE;
            end

            S_COPY:
            begin
                // commit copies element to committed store, revert the other way
                if (op_reg == pmv_pkg::OP_COMMIT)
                begin
                    com_req.wr_en    = 1'b1;
                    com_req.wr_addr  = cnt_reg;
                    com_req.wr_data  = copy_data;
                    elem_req.rd_addr = cnt_reg + pmv_pkg::IDX_W'(1);
                end
                else
                begin
                    elem_req.wr_en   = 1'b1;
                    elem_req.wr_addr = cnt_reg;
                    elem_req.wr_data = copy_data;
                    com_req.rd_addr  = cnt_reg + pmv_pkg::IDX_W'(1);
                end
                if (cnt_reg == pmv_pkg::IDX_W'(pmv_pkg::MAX_ELEMENTS - 1))
                begin
                    strobe_next = 1'b1;
                    result_next = make_result(pmv_pkg::ST_OK, pmv_pkg::KIND_NONE,
                                              '0, '0, '0, 1'b1);
                    state_next  = S_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + pmv_pkg::IDX_W'(1);
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg                <= S_IDLE;
            cur_len_reg              <= '0;
            com_len_reg              <= '0;
            cfg_reg.value_count      <= pmv_pkg::LEN_W'(32);
            cfg_reg.min_length       <= '0;
            cfg_reg.max_length       <= pmv_pkg::LEN_W'(32);
            cfg_reg.start_length     <= pmv_pkg::LEN_W'(32);
            strobe_reg               <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cur_len_reg <= cur_len_next;
            com_len_reg <= com_len_next;
            cfg_reg     <= cfg_next;
            strobe_reg  <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        cnt_reg    <= cnt_next;
        carry_reg  <= carry_next;
        va_reg     <= va_next;
        result_reg <= result_next;
    end

    assign busy           = (state_reg != S_IDLE);
    assign result_strobe  = strobe_reg;
    assign status         = result_reg.status;
    assign kind           = result_reg.kind;
    assign position       = result_reg.position;
    assign old_value      = result_reg.old_value;
    assign new_value      = result_reg.new_value;
    assign last           = result_reg.last;
    assign visible_length = cur_len_reg;
    assign len_diff       = {1'b0, cur_len_reg} - {1'b0, com_len_reg};
    assign length_change  = signed'(len_diff);

    `PMV_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)
    `PMV_ASSERT_NEXT(a_last_gap, clk, rst_n, result_strobe && last, !result_strobe)
    `PMV_ASSERT_SAME(a_record_ok, clk, rst_n, result_strobe && (kind != pmv_pkg::KIND_NONE), status == pmv_pkg::ST_OK)
    `PMV_ASSERT_SAME(a_len_bound, clk, rst_n, result_strobe, visible_length <= pmv_pkg::LEN_W'(pmv_pkg::MAX_ELEMENTS))

endmodule
